@@ src/x86alu_pkg.sv @@
// Shared opcode codes and flag type for the x86 integer ALU.
package x86alu_pkg;

  typedef enum logic [3:0] {
    MODE_CMP  = 4'd0,
    MODE_ADD  = 4'd1,
    MODE_ADC  = 4'd2,
    MODE_SUB  = 4'd3,
    MODE_SBB  = 4'd4,
    MODE_INC  = 4'd5,
    MODE_DEC  = 4'd6,
    MODE_AND  = 4'd7,
    MODE_OR   = 4'd8,
    MODE_XOR  = 4'd9,
    MODE_NOT  = 4'd10,
    MODE_NEG  = 4'd11,
    MODE_XCHG = 4'd12
  } mode_e;

  typedef enum logic [1:0] {
    SIZE_BYTE  = 2'd0,
    SIZE_WORD  = 2'd1,
    SIZE_DWORD = 2'd2,
    SIZE_QWORD = 2'd3
  } size_e;

  typedef struct packed {
    logic of;
    logic sf;
    logic zf;
    logic cf;
  } flags_t;

endpackage

@@ src/x86alu_core.sv @@
// Combinational x86 ALU datapath: width masking, add/sub/logic ops and flags.
module x86alu_core #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic [3:0]            mode_i,
  input  logic [1:0]            size_code_i,
  input  logic [DATA_WIDTH-1:0] a_i,
  input  logic [DATA_WIDTH-1:0] b_i,
  input  x86alu_pkg::flags_t    flags_i,
  output logic [DATA_WIDTH-1:0] result_o,
  output logic [DATA_WIDTH-1:0] swap_o,
  output logic                  write_first_o,
  output logic                  write_second_o,
  output x86alu_pkg::flags_t    flags_o
);
  import x86alu_pkg::*;

  // effective widths, capped at the datapath width
  localparam int unsigned WB = (DATA_WIDTH < 8)  ? DATA_WIDTH : 8;
  localparam int unsigned WW = (DATA_WIDTH < 16) ? DATA_WIDTH : 16;
  localparam int unsigned WD = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam int unsigned WQ = (DATA_WIDTH < 64) ? DATA_WIDTH : 64;

  localparam logic [DATA_WIDTH-1:0] MASK_B = {DATA_WIDTH{1'b1}} >> (DATA_WIDTH - WB);
  localparam logic [DATA_WIDTH-1:0] MASK_W = {DATA_WIDTH{1'b1}} >> (DATA_WIDTH - WW);
  localparam logic [DATA_WIDTH-1:0] MASK_D = {DATA_WIDTH{1'b1}} >> (DATA_WIDTH - WD);
  localparam logic [DATA_WIDTH-1:0] MASK_Q = {DATA_WIDTH{1'b1}} >> (DATA_WIDTH - WQ);

  function automatic logic top_bit(input logic [DATA_WIDTH-1:0] v, input size_e sc);
    unique case (sc)
      SIZE_BYTE:  return v[WB-1];
      SIZE_WORD:  return v[WW-1];
      SIZE_DWORD: return v[WD-1];
      default:    return v[WQ-1];
    endcase
  endfunction

  mode_e                  op;
  size_e                  sc;
  logic [DATA_WIDTH-1:0]  mask;
  logic [DATA_WIDTH-1:0]  a, b;
  logic [DATA_WIDTH-1:0]  add_b, sum, add_cv, add_ov;
  logic [DATA_WIDTH-1:0]  sub_a, sub_b, diff, sub_cv, sub_ov;
  logic                   add_c, sub_c;

  assign op = mode_e'(mode_i);
  assign sc = size_e'(size_code_i);

  always_comb begin
    unique case (sc)
      SIZE_BYTE:  mask = MASK_B;
      SIZE_WORD:  mask = MASK_W;
      SIZE_DWORD: mask = MASK_D;
      default:    mask = MASK_Q;
    endcase
  end

  assign a = a_i & mask;
  assign b = b_i & mask;

  // add family: ADD, ADC, INC
  assign add_b  = (op == MODE_INC) ? DATA_WIDTH'(1) : b;
  assign add_c  = (op == MODE_ADC) ? flags_i.cf : 1'b0;
  assign sum    = (a + add_b + DATA_WIDTH'(add_c)) & mask;
  assign add_cv = (a & add_b) | ((a | add_b) & ~sum);
  assign add_ov = (a ^ sum) & (add_b ^ sum);

  // subtract family: CMP, SUB, SBB, DEC, NEG (NEG is 0 - a)
  assign sub_a  = (op == MODE_NEG) ? '0 : a;
  assign sub_b  = (op == MODE_DEC) ? DATA_WIDTH'(1) : ((op == MODE_NEG) ? a : b);
  assign sub_c  = (op == MODE_SBB) ? flags_i.cf : 1'b0;
  assign diff   = (sub_a - sub_b - DATA_WIDTH'(sub_c)) & mask;
  assign sub_cv = (~sub_a & sub_b) | ((~sub_a | sub_b) & diff);
  assign sub_ov = (sub_a ^ sub_b) & (sub_a ^ diff);

  always_comb begin
    result_o       = '0;
    swap_o         = '0;
    write_first_o  = 1'b0;
    write_second_o = 1'b0;
    flags_o        = flags_i;
    unique case (op)
      MODE_ADD, MODE_ADC, MODE_INC: begin
        result_o      = sum;
        write_first_o = 1'b1;
        flags_o.zf    = (sum == '0);
        flags_o.sf    = top_bit(sum, sc);
        flags_o.cf    = (op == MODE_INC) ? flags_i.cf : top_bit(add_cv, sc);
        flags_o.of    = top_bit(add_ov, sc);
      end
      MODE_CMP, MODE_SUB, MODE_SBB, MODE_DEC, MODE_NEG: begin
        result_o      = diff;
        write_first_o = (op != MODE_CMP);
        flags_o.zf    = (diff == '0);
        flags_o.sf    = top_bit(diff, sc);
        flags_o.cf    = (op == MODE_DEC) ? flags_i.cf : top_bit(sub_cv, sc);
        flags_o.of    = top_bit(sub_ov, sc);
      end
      MODE_AND, MODE_OR, MODE_XOR: begin
        if (op == MODE_AND) begin
          result_o = a & b;
        end else if (op == MODE_OR) begin
          result_o = a | b;
        end else begin
          result_o = a ^ b;
        end
        write_first_o = 1'b1;
        flags_o.zf    = (result_o == '0);
        flags_o.sf    = top_bit(result_o, sc);
        flags_o.cf    = 1'b0;
        flags_o.of    = 1'b0;
      end
      MODE_NOT: begin
        result_o      = ~a & mask;
        write_first_o = 1'b1;
      end
      MODE_XCHG: begin
        result_o       = b;
        swap_o         = a;
        write_first_o  = 1'b1;
        write_second_o = 1'b1;
      end
      default: begin
        // undefined opcodes: no writes, flags held
      end
    endcase
  end

endmodule

@@ src/x86_integer_alu_with_flags.sv @@
// Top level of the x86 integer ALU: input register, datapath, result register, flag register.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one instruction word:
//   mode, size code and two 64-bit operands. Output channel
//   (out_valid_o / out_ready_i) carries one result word per instruction:
//   destination values, write enables and the flags after the instruction.
// Path: the result word passes through the input register, then the
//   result register, before it is shown on the output channel.
// Throughput: one instruction word per cycle while the output channel takes
//   result words. The carry/flag register is updated as the instruction moves
//   from the input register into the result register, so an ADC or SBB
//   directly behind an ADD sees the new carry without a bubble.
// Stall: while the result register holds an untaken word, the input
//   register can still take one more word; the block backs up only when
//   both are full. in_ready_o follows out_ready_i combinationally.
// Reset: both valid bits and all four flags (CF, ZF, SF, OF) clear.
// DATA_WIDTH caps the operand width; outputs are zero extended to 64 bits.
module x86_integer_alu_with_flags #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  mode_i,
  input  logic [1:0]  size_code_i,
  input  logic [63:0] operand_a_i,
  input  logic [63:0] operand_b_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] result_value_o,
  output logic [63:0] swap_value_o,
  output logic        write_first_o,
  output logic        write_second_o,
  output logic        carry_out_o,
  output logic        zero_out_o,
  output logic        sign_out_o,
  output logic        overflow_out_o
);
  import x86alu_pkg::*;

  // input register
  logic                  in_valid_q;
  logic [3:0]            mode_q;
  logic [1:0]            size_q;
  logic [DATA_WIDTH-1:0] a_q, b_q;

  // result register
  logic                  out_valid_q;
  logic [DATA_WIDTH-1:0] res_q, swap_q;
  logic                  wf_q, ws_q;
  flags_t                out_flags_q;

  // architectural flags
  flags_t                flags_q, flags_d;

  logic [DATA_WIDTH-1:0] res_d, swap_d;
  logic                  wf_d, ws_d;
  logic                  out_free, advance, in_accept;

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || advance;
  assign in_accept  = in_valid_i && in_ready_o;

  x86alu_core #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_core (
    .mode_i        (mode_q),
    .size_code_i   (size_q),
    .a_i           (a_q),
    .b_i           (b_q),
    .flags_i       (flags_q),
    .result_o      (res_d),
    .swap_o        (swap_d),
    .write_first_o (wf_d),
    .write_second_o(ws_d),
    .flags_o       (flags_d)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flags_q     <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (advance) begin
        flags_q <= flags_d;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mode_q <= mode_i;
      size_q <= size_code_i;
      a_q    <= operand_a_i[DATA_WIDTH-1:0];
      b_q    <= operand_b_i[DATA_WIDTH-1:0];
    end
    if (advance) begin
      res_q       <= res_d;
      swap_q      <= swap_d;
      wf_q        <= wf_d;
      ws_q        <= ws_d;
      out_flags_q <= flags_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = 64'(res_q);
  assign swap_value_o   = 64'(swap_q);
  assign write_first_o  = wf_q;
  assign write_second_o = ws_q;
  assign carry_out_o    = out_flags_q.cf;
  assign zero_out_o     = out_flags_q.zf;
  assign sign_out_o     = out_flags_q.sf;
  assign overflow_out_o = out_flags_q.of;

  // the flags shown with a result word are the architectural flags it left
  a_flags_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_flags_q == flags_q))
    else $error("result flags differ from flag register");

  // flag register only moves when an instruction executes
  a_flags_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(flags_q))
    else $error("flag register changed without an instruction");

  // logic ops always clear CF and OF
  a_logic_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (mode_q == MODE_AND || mode_q == MODE_OR || mode_q == MODE_XOR)
    |=> !carry_out_o && !overflow_out_o)
    else $error("logic op left CF or OF set");

  // second destination is only written together with the first
  a_xchg_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_second_o |-> write_first_o)
    else $error("second write without first write");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the x86 integer ALU with flags.
`timescale 1ns / 1ps

module tb;
  import x86alu_pkg::*;

  localparam int unsigned DATA_W = 64;
  // Opcodes past XCHG are reserved and must do nothing.
  localparam logic [3:0] MODE_RSVD_FIRST = 4'd13;
  localparam logic [3:0] MODE_RSVD_LAST = 4'd15;
  localparam int unsigned RANDOM_WORDS = 700;
  localparam int unsigned IDLE_PCT = 38;
  localparam int unsigned QUIET_FROM = 200;
  localparam int unsigned QUIET_TO = 500;
  localparam int unsigned STALL_AFTER = 200;
  localparam int unsigned STALL_LEN = 60;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned WATCHDOG_LIMIT = 1000;

  typedef struct {
    logic [3:0]  mode;
    size_e       size;
    logic [63:0] a;
    logic [63:0] b;
  } alu_word_t;

  typedef struct {
    logic [63:0] result_value;
    logic [63:0] swap_value;
    logic        wr_first;
    logic        wr_second;
    flags_t      flags;
  } alu_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  mode = '0;
  logic [1:0]  size_code = '0;
  logic [63:0] operand_a = '0;
  logic [63:0] operand_b = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] result_value;
  logic [63:0] swap_value;
  logic        write_first;
  logic        write_second;
  logic        carry_out;
  logic        zero_out;
  logic        sign_out;
  logic        overflow_out;

  alu_word_t   pending_words[$];
  alu_result_t expected_results[$];
  alu_word_t   cur_word;
  flags_t      flag_reg = '0;        // predicted CF/ZF/SF/OF register

  int unsigned cyc = 0;
  int unsigned quiet_cycles = 0;
  int unsigned words_sent = 0;
  int unsigned results_seen = 0;
  int unsigned errors = 0;
  int unsigned stall_left = 0;
  bit          stall_done = 1'b0;

  x86_integer_alu_with_flags #(
    .DATA_WIDTH(DATA_W)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .mode_i         (mode),
    .size_code_i    (size_code),
    .operand_a_i    (operand_a),
    .operand_b_i    (operand_b),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .result_value_o (result_value),
    .swap_value_o   (swap_value),
    .write_first_o  (write_first),
    .write_second_o (write_second),
    .carry_out_o    (carry_out),
    .zero_out_o     (zero_out),
    .sign_out_o     (sign_out),
    .overflow_out_o (overflow_out)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Random idle decision for either side, with one window of full rate.
  function automatic bit idle_now();
    if (cyc >= QUIET_FROM && cyc < QUIET_TO) return 1'b0;
    return $urandom_range(99) < IDLE_PCT;
  endfunction

  function automatic int unsigned op_width(input size_e sz);
    int unsigned w;
    w = 8 << sz;
    return (w > DATA_W) ? DATA_W : w;
  endfunction

  function automatic logic [63:0] width_mask(input int unsigned w);
    return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
  endfunction

  // Golden ALU: computes one result word and advances the flag register.
  function automatic alu_result_t alu_predict(input alu_word_t wd);
    int unsigned w;
    logic [63:0] m, a, b, x, y, cin, r, cv, ov;
    flags_t      f;
    alu_result_t o;
    w = op_width(wd.size);
    m = width_mask(w);
    a = wd.a & m;
    b = wd.b & m;
    cin = {63'd0, flag_reg.cf};
    f = flag_reg;
    r = '0;
    o.swap_value = '0;
    o.wr_first = 1'b0;
    o.wr_second = 1'b0;
    case (wd.mode)
      MODE_ADD, MODE_ADC, MODE_INC: begin
        y = (wd.mode == MODE_INC) ? 64'd1 : b;
        r = (a + y + ((wd.mode == MODE_ADC) ? cin : 64'd0)) & m;
        f.zf = (r == 0);
        f.sf = r[w-1];
        cv = (a & y) | ((a | y) & ~r);
        ov = (a ^ r) & (y ^ r);
        // INC leaves CF alone
        if (wd.mode != MODE_INC) f.cf = cv[w-1];
        f.of = ov[w-1];
        o.wr_first = 1'b1;
      end
      MODE_CMP, MODE_SUB, MODE_SBB, MODE_DEC, MODE_NEG: begin
        // NEG is 0 - a; DEC subtracts one
        x = (wd.mode == MODE_NEG) ? 64'd0 : a;
        y = (wd.mode == MODE_DEC) ? 64'd1 : ((wd.mode == MODE_NEG) ? a : b);
        r = (x - y - ((wd.mode == MODE_SBB) ? cin : 64'd0)) & m;
        f.zf = (r == 0);
        f.sf = r[w-1];
        cv = (~x & y) | ((~x | y) & r);
        ov = (x ^ y) & (x ^ r);
        if (wd.mode != MODE_DEC) f.cf = cv[w-1];
        f.of = ov[w-1];
        o.wr_first = (wd.mode != MODE_CMP);
      end
      MODE_AND, MODE_OR, MODE_XOR: begin
        if (wd.mode == MODE_AND) r = a & b;
        else if (wd.mode == MODE_OR) r = a | b;
        else r = a ^ b;
        f.zf = (r == 0);
        f.sf = r[w-1];
        f.cf = 1'b0;
        f.of = 1'b0;
        o.wr_first = 1'b1;
      end
      MODE_NOT: begin
        r = ~a & m;
        o.wr_first = 1'b1;
      end
      MODE_XCHG: begin
        r = b;
        o.swap_value = a;
        o.wr_first = 1'b1;
        o.wr_second = 1'b1;
      end
      default: ;  // reserved: nothing written, flags kept
    endcase
    flag_reg = f;
    o.result_value = r;
    o.flags = f;
    return o;
  endfunction

  task automatic add_word(input logic [3:0] md, input size_e sz,
                          input logic [63:0] a, input logic [63:0] b);
    alu_word_t wd;
    wd.mode = md;
    wd.size = sz;
    wd.a = a;
    wd.b = b;
    pending_words.push_back(wd);
  endtask

  // Operand with a corner or random value in the live width and optional junk above it.
  function automatic logic [63:0] rand_operand(input size_e sz);
    int unsigned w;
    logic [63:0] m, low, junk;
    w = op_width(sz);
    m = width_mask(w);
    case ($urandom_range(9))
      0: low = '0;
      1: low = '1;
      2: low = 64'd1 << (w - 1);
      3: low = (64'd1 << (w - 1)) - 64'd1;
      4: low = 64'($urandom_range(3));
      default: low = {$urandom, $urandom};
    endcase
    junk = $urandom_range(1) ? {$urandom, $urandom} : '0;
    return (junk & ~m) | (low & m);
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $realtime, name, want, got);
    end
  endtask

  // Driver: presents one instruction word at a time, predicting on accept.
  always @(posedge clk_i or negedge rst_ni) begin
    logic slot_free;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      slot_free = !in_valid;
      if (in_valid && in_ready) begin
        expected_results.push_back(alu_predict(cur_word));
        words_sent++;
        slot_free = 1'b1;
      end
      if (slot_free) begin
        if (pending_words.size() != 0 && !idle_now()) begin
          cur_word = pending_words.pop_front();
          in_valid <= 1'b1;
          mode <= cur_word.mode;
          size_code <= cur_word.size;
          operand_a <= cur_word.a;
          operand_b <= cur_word.b;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result word against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    alu_result_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: result word with none expected, actual %h", $realtime,
                   result_value);
        end else begin
          want = expected_results.pop_front();
          check_field("result_value", want.result_value, result_value);
          check_field("swap_value", want.swap_value, swap_value);
          check_field("write_first", 64'(want.wr_first), 64'(write_first));
          check_field("write_second", 64'(want.wr_second), 64'(write_second));
          check_field("carry_out", 64'(want.flags.cf), 64'(carry_out));
          check_field("zero_out", 64'(want.flags.zf), 64'(zero_out));
          check_field("sign_out", 64'(want.flags.sf), 64'(sign_out));
          check_field("overflow_out", 64'(want.flags.of), 64'(overflow_out));
        end
      end
      // one long hold-off so both internal registers fill and input stalls
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!stall_done && results_seen >= STALL_AFTER) begin
        stall_done = 1'b1;
        stall_left = STALL_LEN - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !idle_now();
      end
    end
  end

  // Cycle count and watchdog on cycles with no word moving on either side.
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $realtime, quiet_cycles);
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned n, pick, links;
    size_e sz;
    logic [3:0] head;

    // Directed: width extremes, carry/borrow/overflow edges, every opcode.
    add_word(MODE_ADD, SIZE_BYTE, 64'hDEAD_BEEF_CAFE_00FF, 64'h1234_0001);  // wraps to 0
    add_word(MODE_ADC, SIZE_BYTE, 64'h0, 64'h0);                            // carry in
    add_word(MODE_ADD, SIZE_BYTE, 64'h7F, 64'h01);                          // signed ovf
    add_word(MODE_SUB, SIZE_WORD, 64'h0, 64'h1);                            // borrow
    add_word(MODE_SBB, SIZE_WORD, 64'h8000, 64'h0);                         // borrow in, ovf
    add_word(MODE_CMP, SIZE_DWORD, 64'hFFFF_FFFF_1234_5678, 64'h1234_5678); // equal
    add_word(MODE_CMP, SIZE_QWORD, 64'h0, 64'h1);
    add_word(MODE_INC, SIZE_BYTE, 64'h7F, 64'h0);                           // ovf, CF kept
    add_word(MODE_INC, SIZE_WORD, 64'hFFFF, 64'hFFFF);
    add_word(MODE_DEC, SIZE_DWORD, 64'h8000_0000, 64'h0);
    add_word(MODE_DEC, SIZE_QWORD, 64'h0, 64'h0);
    add_word(MODE_NEG, SIZE_BYTE, 64'h100, 64'hFF);                         // neg of zero
    add_word(MODE_NEG, SIZE_BYTE, 64'h80, 64'h0);                           // most negative
    add_word(MODE_NEG, SIZE_QWORD, 64'h1, 64'h0);
    add_word(MODE_AND, SIZE_QWORD, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
    add_word(MODE_OR, SIZE_WORD, 64'hFFFF_0000, 64'h0);
    add_word(MODE_XOR, SIZE_DWORD, 64'h5A5A_5A5A, 64'h5A5A_5A5A);
    add_word(MODE_SUB, SIZE_BYTE, 64'h0, 64'h1);
    add_word(MODE_NOT, SIZE_BYTE, 64'hAB, 64'h0);                           // flags held
    add_word(MODE_NOT, SIZE_QWORD, 64'h0, 64'h0);
    add_word(MODE_XCHG, SIZE_WORD, 64'h1111_2222, 64'h3333_4444);
    add_word(MODE_RSVD_FIRST, SIZE_QWORD, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1);
    add_word(MODE_RSVD_LAST, SIZE_BYTE, 64'h12, 64'h34);
    add_word(MODE_ADD, SIZE_QWORD, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    add_word(MODE_SBB, SIZE_QWORD, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);

    // Random: 30 percent of picks are multi-word carry chains, 6 percent reserved codes.
    n = 0;
    while (n < RANDOM_WORDS) begin
      pick = $urandom_range(99);
      sz = size_e'($urandom_range(SIZE_QWORD));
      if (pick < 30) begin
        head = $urandom_range(1) ? MODE_ADD : MODE_SUB;
        add_word(head, sz, rand_operand(sz), rand_operand(sz));
        links = $urandom_range(3, 1);
        repeat (links) begin
          add_word((head == MODE_ADD) ? MODE_ADC : MODE_SBB, sz,
                   rand_operand(sz), rand_operand(sz));
        end
        n += links + 1;
      end else if (pick < 36) begin
        add_word(4'($urandom_range(MODE_RSVD_LAST, MODE_RSVD_FIRST)), sz,
                 rand_operand(sz), rand_operand(sz));
        n++;
      end else begin
        add_word(4'($urandom_range(MODE_XCHG)), sz, rand_operand(sz), rand_operand(sz));
        n++;
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("summary: %0d instruction words sent, %0d result words checked, %0d errors",
             words_sent, results_seen, errors);
    $display("summary: all opcodes and reserved codes, four sizes, carry chains, %0d-cycle hold",
             STALL_LEN);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/x86alu_pkg.sv
src/x86alu_core.sv
src/x86_integer_alu_with_flags.sv
tb/tb.sv
